/* hdl/can_frame_receive_fifo_defines.svh */
// assertion macros for the can frame receive fifo checker
// no dependencies; expects clk and arst_n in the scope of use
`ifndef CAN_FRAME_RECEIVE_FIFO_DEFINES_SVH
`define CAN_FRAME_RECEIVE_FIFO_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CFRF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CFRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cfrf_pkg.sv */
// shared types, constants and helpers of the can frame receive fifo
// no dependencies
package cfrf_pkg;

	localparam int CAPACITY = 15;
	localparam int SLOTS    = CAPACITY + 1;
	localparam int PTR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int OP_W     = 2;
	localparam int ID_IN_W  = 29;
	localparam int ID_W     = 11;
	localparam int LEN_W    = 4;
	localparam int PAY_W    = 64;
	localparam int CNT_W    = 32;
	localparam int STAT_W   = 2;

	localparam logic [ID_IN_W-1:0] MAX_ID  = ID_IN_W'(11'h7ff);
	localparam logic [LEN_W-1:0]   MAX_LEN = LEN_W'(8);

	localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_BUS_OFF = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd3;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [ID_W-1:0]  identifier;
		logic [LEN_W-1:0] length;
		logic [PAY_W-1:0] payload;
	} frame_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	function automatic ptr_t ring_next(input ptr_t p);
		ptr_t n;
		n = (p == ptr_t'(SLOTS - 1)) ? '0 : ptr_t'(p + 1'b1);
		return n;
	endfunction

endpackage

/* hdl/cfrf_cmd_if.sv */
// operation channel of the can frame receive fifo
// depends on cfrf_pkg
interface cfrf_cmd_if
	import cfrf_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [ID_IN_W-1:0]   in_identifier;
	logic [LEN_W-1:0]     in_length;
	logic [PAY_W-1:0]     in_payload;

	modport source (output valid, op, in_identifier, in_length, in_payload, input ready);
	modport sink   (input valid, op, in_identifier, in_length, in_payload, output ready);
endinterface

/* hdl/cfrf_rsp_if.sv */
// result channel of the can frame receive fifo
// depends on cfrf_pkg
interface cfrf_rsp_if
	import cfrf_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [ID_W-1:0]      out_identifier;
	logic [LEN_W-1:0]     out_length;
	logic [PAY_W-1:0]     out_payload;
	logic [CNT_W-1:0]     received_total;
	logic [CNT_W-1:0]     dropped_total;
	logic                 bus_off_flag;
	logic [CNT_W-1:0]     bus_off_events;

	modport source (output valid, status, out_identifier, out_length, out_payload,
		received_total, dropped_total, bus_off_flag, bus_off_events, input ready);
	modport sink   (input valid, status, out_identifier, out_length, out_payload,
		received_total, dropped_total, bus_off_flag, bus_off_events, output ready);
endinterface

/* hdl/cfrf_ctrl.sv */
// controller state machine of the can frame receive fifo
// depends on cfrf_pkg
module cfrf_ctrl
	import cfrf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output dp_cmd_t dp_cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (rsp_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_ready   = (state_q == S_IDLE);
	assign rsp_valid   = (state_q == S_RESP);
	assign dp_cmd.load = cmd_valid && (state_q == S_IDLE);
	assign dp_cmd.exec = (state_q == S_EXEC);

endmodule

/* hdl/cfrf_datapath.sv */
// datapath of the can frame receive fifo: frame ring, pointers, counters
// depends on cfrf_pkg
module cfrf_datapath
	import cfrf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             dp_cmd,
	input  logic [OP_W-1:0]     op,
	input  logic [ID_IN_W-1:0]  in_identifier,
	input  logic [LEN_W-1:0]    in_length,
	input  logic [PAY_W-1:0]    in_payload,
	output logic [STAT_W-1:0]   status,
	output logic [ID_W-1:0]     out_identifier,
	output logic [LEN_W-1:0]    out_length,
	output logic [PAY_W-1:0]    out_payload,
	output logic [CNT_W-1:0]    received_total,
	output logic [CNT_W-1:0]    dropped_total,
	output logic                bus_off_flag,
	output logic [CNT_W-1:0]    bus_off_events
);

	logic [OP_W-1:0]    op_q;
	logic [ID_IN_W-1:0] id_q;
	logic [LEN_W-1:0]   len_q;
	logic [PAY_W-1:0]   pay_q;

	frame_t      ring_q [SLOTS];
	frame_t      rd_frame_q;
	ptr_t        wr_ptr_q;
	ptr_t        rd_ptr_q;
	cnt_t        recv_q;
	cnt_t        drop_q;
	cnt_t        bo_cnt_q;
	logic        bo_flag_q;
	logic [STAT_W-1:0] status_q;

	ptr_t              wr_next;
	logic              frame_ok;
	logic              full;
	logic              empty;
	logic              push_ok;
	logic              push_drop;
	logic              pop_ok;
	logic              bus_off;
	logic [STAT_W-1:0] status_d;

	// captured operation
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			op_q  <= op;
			id_q  <= in_identifier;
			len_q <= in_length;
			pay_q <= in_payload;
		end
	end

	assign wr_next  = ring_next(wr_ptr_q);
	assign frame_ok = (id_q <= MAX_ID) && (len_q <= MAX_LEN);
	assign full     = (wr_next == rd_ptr_q);
	assign empty    = (rd_ptr_q == wr_ptr_q);

	always_comb begin
		push_ok   = 1'b0;
		push_drop = 1'b0;
		pop_ok    = 1'b0;
		bus_off   = 1'b0;
		status_d  = STAT_INVALID;
		case (op_q)
			OP_PUSH: begin
				if (frame_ok) begin
					if (full) begin
						push_drop = 1'b1;
						status_d  = STAT_FULL;
					end else begin
						push_ok  = 1'b1;
						status_d = STAT_OK;
					end
				end
			end
			OP_POP: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					pop_ok   = 1'b1;
					status_d = STAT_OK;
				end
			end
			OP_BUS_OFF: begin
				bus_off  = 1'b1;
				status_d = STAT_OK;
			end
			default: begin
				status_d = STAT_INVALID;
			end
		endcase
	end

	// frame ring
	always_ff @(posedge clk) begin
		if (dp_cmd.exec && push_ok) begin
			ring_q[wr_ptr_q] <= '{identifier: id_q[ID_W-1:0], length: len_q, payload: pay_q};
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			rd_frame_q <= pop_ok ? ring_q[rd_ptr_q] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			recv_q    <= '0;
			drop_q    <= '0;
			bo_cnt_q  <= '0;
			bo_flag_q <= 1'b0;
			status_q  <= STAT_OK;
		end else if (dp_cmd.exec) begin
			status_q <= status_d;
			if (push_ok) begin
				wr_ptr_q <= wr_next;
				recv_q   <= recv_q + 1'b1;
			end
			if (push_drop) drop_q <= drop_q + 1'b1;
			if (pop_ok) rd_ptr_q <= ring_next(rd_ptr_q);
			if (bus_off) begin
				bo_flag_q <= 1'b1;
				bo_cnt_q  <= bo_cnt_q + 1'b1;
			end
		end
	end

	assign status         = status_q;
	assign out_identifier = rd_frame_q.identifier;
	assign out_length     = rd_frame_q.length;
	assign out_payload    = rd_frame_q.payload;
	assign received_total = recv_q;
	assign dropped_total  = drop_q;
	assign bus_off_flag   = bo_flag_q;
	assign bus_off_events = bo_cnt_q;

endmodule

/* hdl/can_frame_receive_fifo.sv */
// top level of the can frame receive fifo: controller plus datapath
// depends on cfrf_pkg, cfrf_cmd_if, cfrf_rsp_if, cfrf_ctrl, cfrf_datapath
//
// usage
// cmd carries one operation per transfer: push a frame, pop the oldest
// frame, or signal a bus-off event. rsp returns exactly one result per
// operation: a status code, the popped frame (zero unless a pop succeeds)
// and the reception, drop and bus-off counters as they stand afterwards.
// the ring holds up to 15 frames; a push of an in-range frame on a full ring
// is dropped and counted, a pop on an empty ring reports empty, and a
// push of an out-of-range frame or an unused op code reports invalid.
// one operation is in flight at a time. the transfer on cmd is taken in
// the capture (idle) state, the ring and counters update in the execute
// state, and the result is offered on rsp from the result state of the
// controller; no new transfer is taken until the result is taken.
// while rsp is stalled the result holds and cmd.ready stays low.
// reset clears the pointers, counters and bus-off flag at once; the ring
// contents are not cleared, and no pop ever reads an unwritten slot.
module can_frame_receive_fifo
	import cfrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cfrf_cmd_if.sink    cmd,
	cfrf_rsp_if.source  rsp
);

	dp_cmd_t dp_cmd;

	cfrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_cmd    (dp_cmd)
	);

	cfrf_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.op             (cmd.op),
		.in_identifier  (cmd.in_identifier),
		.in_length      (cmd.in_length),
		.in_payload     (cmd.in_payload),
		.status         (rsp.status),
		.out_identifier (rsp.out_identifier),
		.out_length     (rsp.out_length),
		.out_payload    (rsp.out_payload),
		.received_total (rsp.received_total),
		.dropped_total  (rsp.dropped_total),
		.bus_off_flag   (rsp.bus_off_flag),
		.bus_off_events (rsp.bus_off_events)
	);

endmodule

/* hdl/cfrf_checker.sv */
// port-level checks of the can frame receive fifo, bound to the top level
// depends on cfrf_pkg, cfrf_cmd_if, cfrf_rsp_if, can_frame_receive_fifo_defines.svh
`include "can_frame_receive_fifo_defines.svh"

module cfrf_checker
	import cfrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cfrf_cmd_if.sink    cmd,
	cfrf_rsp_if.source  rsp
);

	`CFRF_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.status) && $stable(rsp.out_payload), "stalled result changed")
	`CFRF_ASSERT_NEXT(a_flag_sticky, rsp.bus_off_flag, rsp.bus_off_flag, "bus-off flag cleared")
	`CFRF_ASSERT_NOW(a_frame_zero, rsp.valid && rsp.status != STAT_OK, rsp.out_identifier == '0 && rsp.out_length == '0 && rsp.out_payload == '0, "frame fields not zero")
	`CFRF_ASSERT_NOW(a_len_range, rsp.valid, rsp.out_length <= MAX_LEN, "popped length above eight")
	`CFRF_ASSERT_NEXT(a_one_in_flight, cmd.valid && cmd.ready, !rsp.valid && !cmd.ready, "result or transfer too early")

endmodule

bind can_frame_receive_fifo cfrf_checker u_cfrf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.rsp    (rsp)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// testbench for can_frame_receive_fifo: push, pop, bus-off and unused operations
// checked against a ring model kept in the bench; needs cfrf_pkg, cfrf_cmd_if, cfrf_rsp_if
module tb;
	import cfrf_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int STALL_HOLD  = 400;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		frame_t            frame;
		cnt_t              received;
		cnt_t              dropped;
		logic              bus_off;
		cnt_t              bus_off_events;
	} fifo_reply_t;

	logic clk;
	logic arst_n;

	cfrf_cmd_if cmd ();
	cfrf_rsp_if rsp ();

	can_frame_receive_fifo DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	frame_t      ring_frames [SLOTS];
	ptr_t        ring_wr;
	ptr_t        ring_rd;
	cnt_t        ring_received;
	cnt_t        ring_dropped;
	cnt_t        ring_bus_off_events;
	logic        ring_bus_off;
	fifo_reply_t pending_replies [$];
	int          errors;
	bit          sender_idles;
	bit          receiver_stalls;
	int          hold_request;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic ptr_t ring_advance(input ptr_t p);
		return (p == ptr_t'(SLOTS - 1)) ? ptr_t'(0) : ptr_t'(p + 1'b1);
	endfunction

	function automatic fifo_reply_t ring_apply(input logic [OP_W-1:0] op,
		input logic [ID_IN_W-1:0] ident, input logic [LEN_W-1:0] len,
		input logic [PAY_W-1:0] pay);
		fifo_reply_t r;
		ptr_t        nxt;
		r = '0;
		r.status = STAT_INVALID;
		case (op)
			OP_PUSH: begin
				if (ident <= MAX_ID && len <= MAX_LEN) begin
					nxt = ring_advance(ring_wr);
					if (nxt == ring_rd) begin
						ring_dropped = ring_dropped + 1'b1;
						r.status = STAT_FULL;
					end else begin
						ring_frames[ring_wr].identifier = ident[ID_W-1:0];
						ring_frames[ring_wr].length = len;
						ring_frames[ring_wr].payload = pay;
						ring_wr = nxt;
						ring_received = ring_received + 1'b1;
						r.status = STAT_OK;
					end
				end
			end
			OP_POP: begin
				if (ring_rd == ring_wr) begin
					r.status = STAT_EMPTY;
				end else begin
					r.frame = ring_frames[ring_rd];
					ring_rd = ring_advance(ring_rd);
					r.status = STAT_OK;
				end
			end
			OP_BUS_OFF: begin
				ring_bus_off = 1'b1;
				ring_bus_off_events = ring_bus_off_events + 1'b1;
				r.status = STAT_OK;
			end
			default: begin
			end
		endcase
		r.received = ring_received;
		r.dropped = ring_dropped;
		r.bus_off = ring_bus_off;
		r.bus_off_events = ring_bus_off_events;
		return r;
	endfunction

	// one operation per transfer; valid stays high into the next call unless it idles
	task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_IN_W-1:0] ident,
		input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] pay);
		int gap;
		gap = 0;
		if (sender_idles) begin
			while ($urandom_range(99) < 9)
				gap++;
		end
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.in_identifier <= ident;
		cmd.in_length <= len;
		cmd.in_payload <= pay;
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		pending_replies.push_back(ring_apply(op, ident, len, pay));
	endtask

	task automatic send_random(input int push_pct);
		int                 pick;
		logic [ID_IN_W-1:0] junk_id;
		logic [LEN_W-1:0]   junk_len;
		logic [PAY_W-1:0]   pay;
		pick = $urandom_range(99);
		junk_id = ID_IN_W'($urandom);
		junk_len = LEN_W'($urandom);
		pay = {$urandom, $urandom};
		if (pick < 3)
			send_op(OP_UNUSED, junk_id, junk_len, pay);
		else if (pick < 7)
			send_op(OP_BUS_OFF, junk_id, junk_len, pay);
		else if (pick < 11)
			send_op(OP_PUSH, ID_IN_W'($urandom_range(29'h1fffffff, 29'h800)), junk_len, pay);
		else if (pick < 15)
			send_op(OP_PUSH, ID_IN_W'($urandom_range(2047, 0)),
				LEN_W'($urandom_range(15, 9)), pay);
		else if ($urandom_range(99) < push_pct)
			send_op(OP_PUSH, ID_IN_W'($urandom_range(2047, 0)),
				LEN_W'($urandom_range(8, 0)), pay);
		else
			send_op(OP_POP, junk_id, junk_len, pay);
	endtask

	task automatic test_special_cases();
		send_op(OP_POP, '1, '1, '1);
		send_op(OP_PUSH, ID_IN_W'(29'h800), '0, '0);
		send_op(OP_PUSH, '1, '1, '1);
		send_op(OP_PUSH, MAX_ID, LEN_W'(9), '1);
		send_op(OP_UNUSED, '0, '0, '0);
		send_op(OP_BUS_OFF, '0, '0, '0);
		send_op(OP_PUSH, '0, '0, '0);
		send_op(OP_POP, '0, '0, '0);
	endtask

	task automatic test_fill_and_drop();
		send_op(OP_PUSH, MAX_ID, MAX_LEN, '1);
		repeat (CAPACITY - 1)
			send_op(OP_PUSH, ID_IN_W'($urandom_range(2047, 0)), LEN_W'($urandom_range(8, 0)),
				{$urandom, $urandom});
		send_op(OP_PUSH, ID_IN_W'(29'h123), LEN_W'(4), {$urandom, $urandom});
		send_op(OP_POP, '0, '0, '0);
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			sender_idles = !(i >= count * 2 / 5 && i < count * 3 / 5);
			receiver_stalls = sender_idles;
			case ((i / 40) % 3)
				0: send_random(75);
				1: send_random(25);
				default: send_random(50);
			endcase
		end
	endtask

	task automatic test_output_stall();
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		hold_request = STALL_HOLD;
		repeat (45) send_random(80);
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= !(receiver_stalls && $urandom_range(99) < 9);
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want_v,
		input logic [63:0] got);
		if (got !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		fifo_reply_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_replies.size() == 0) begin
				$error("result with none pending: status %0h", rsp.status);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				check_field("status", 64'(want.status), 64'(rsp.status));
				check_field("out_identifier", 64'(want.frame.identifier), 64'(rsp.out_identifier));
				check_field("out_length", 64'(want.frame.length), 64'(rsp.out_length));
				check_field("out_payload", want.frame.payload, rsp.out_payload);
				check_field("received_total", 64'(want.received), 64'(rsp.received_total));
				check_field("dropped_total", 64'(want.dropped), 64'(rsp.dropped_total));
				check_field("bus_off_flag", 64'(want.bus_off), 64'(rsp.bus_off_flag));
				check_field("bus_off_events", 64'(want.bus_off_events), 64'(rsp.bus_off_events));
			end
		end
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = OP_PUSH;
		cmd.in_identifier = '0;
		cmd.in_length = '0;
		cmd.in_payload = '0;
		ring_wr = '0;
		ring_rd = '0;
		ring_received = '0;
		ring_dropped = '0;
		ring_bus_off_events = '0;
		ring_bus_off = 1'b0;
		errors = 0;
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		hold_request = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_fill_and_drop();
		test_random_traffic(540);
		test_output_stall();
		test_random_traffic(540);

		cmd.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/cfrf_pkg.sv
hdl/cfrf_cmd_if.sv
hdl/cfrf_rsp_if.sv
hdl/cfrf_ctrl.sv
hdl/cfrf_datapath.sv
hdl/can_frame_receive_fifo.sv
hdl/cfrf_checker.sv
test/tb.sv
